// ----- hdl/sd_pkg.sv -----
// Shared types, constants and microcode for the sample standard deviation core.
// Used by sd_seq, sd_datapath and sample_standard_deviation_core; no dependencies.
package sd_pkg;

	localparam int MaxSamples = 4096;
	localparam int CountW     = $clog2(MaxSamples + 1);
	localparam int SumW       = 29;
	localparam int SqSumW     = 43;
	localparam int MagW       = 28;
	localparam int AccW       = 56;
	localparam int NumW       = 71;
	localparam int DenW       = 24;
	localparam int RemW       = 26;
	localparam int DevW       = 24;
	localparam int CntW       = 7;
	localparam int SqrtSteps  = DevW;

	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusShort    = 2'd1;
	localparam logic [1:0] StatusOverflow = 2'd2;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [DevW-1:0] deviation;
		logic [1:0]      status;
	} result_t;

	typedef enum logic [2:0] {
		OpMulHi,
		OpMacLo,
		OpSubSq,
		OpDen,
		OpDivStep,
		OpSqrtInit,
		OpSqrtStep,
		OpFinish
	} op_t;

	typedef logic [2:0] upc_t;

	typedef struct packed {
		op_t            op;
		logic           cnt_load;
		logic [CntW-1:0] cnt_init;
		logic           loop;
		upc_t           target;
	} uword_t;

	localparam upc_t PcDiv  = 3'd4;
	localparam upc_t PcSqrt = 3'd6;

	// Program: n*S2 - S1^2, n*(n-1), long division with 16 extra fraction
	// bits, then digit-by-digit square root.
	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w = '{op: OpFinish, cnt_load: 1'b0, cnt_init: '0, loop: 1'b0, target: '0};
		case (pc)
			3'd0: w.op = OpMulHi;
			3'd1: w.op = OpMacLo;
			3'd2: w.op = OpSubSq;
			3'd3: begin
				w.op       = OpDen;
				w.cnt_load = 1'b1;
				w.cnt_init = CntW'(NumW - 1);
			end
			3'd4: begin
				w.op     = OpDivStep;
				w.loop   = 1'b1;
				w.target = PcDiv;
			end
			3'd5: begin
				w.op       = OpSqrtInit;
				w.cnt_load = 1'b1;
				w.cnt_init = CntW'(SqrtSteps - 1);
			end
			3'd6: begin
				w.op     = OpSqrtStep;
				w.loop   = 1'b1;
				w.target = PcSqrt;
			end
			default: w.op = OpFinish;
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/sd_seq.sv -----
// Microcode sequencer: step counter, loop counter and program lookup.
// Depends on sd_pkg (control word type and program table).
module sd_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           drain,
	output sd_pkg::uword_t uw,
	output logic           running
);

	sd_pkg::upc_t              pc_q;
	logic [sd_pkg::CntW-1:0]   cnt_q;
	logic                      running_q;

	assign uw      = sd_pkg::ucode(pc_q);
	assign running = running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			cnt_q     <= '0;
			running_q <= 1'b0;
		end else if (start) begin
			pc_q      <= '0;
			running_q <= 1'b1;
		end else if (running_q) begin
			if (uw.op == sd_pkg::OpFinish) begin
				// hold on the last step until the output register frees up
				if (drain) begin
					running_q <= 1'b0;
				end
			end else begin
				if (uw.cnt_load) begin
					cnt_q <= uw.cnt_init;
				end
				if (uw.loop && cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					pc_q  <= uw.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/sd_datapath.sv -----
// Datapath driven by the microcode: shared multiplier with accumulator,
// restoring divider and digit-by-digit square root. Depends on sd_pkg.
module sd_datapath (
	input  logic                      clk,
	input  logic                      load,
	input  logic [sd_pkg::CountW-1:0] n,
	input  logic [sd_pkg::MagW-1:0]   mag,
	input  logic [sd_pkg::SqSumW-1:0] s2,
	input  logic                      en,
	input  sd_pkg::op_t               op,
	output logic [sd_pkg::DevW-1:0]   deviation
);

	logic [sd_pkg::CountW-1:0] n_q;
	logic [sd_pkg::MagW-1:0]   mag_q;
	logic [sd_pkg::SqSumW-1:0] s2_q;
	logic [sd_pkg::AccW-1:0]   acc_q;
	logic [sd_pkg::DenW-1:0]   den_q;
	logic [sd_pkg::NumW-1:0]   num_q;
	logic [sd_pkg::RemW-1:0]   rem_q;
	logic [sd_pkg::DevW-1:0]   root_q;

	logic [sd_pkg::MagW-1:0]   mul_a;
	logic [sd_pkg::MagW-1:0]   mul_b;
	logic [sd_pkg::AccW-1:0]   prod;

	logic [sd_pkg::DenW:0]     div_cat;
	logic [sd_pkg::DenW+1:0]   div_diff;
	logic                      div_ok;

	logic [sd_pkg::RemW+1:0]   sq_cat;
	logic [sd_pkg::RemW+2:0]   sq_diff;
	logic                      sq_ok;

	always_comb begin
		case (op)
			sd_pkg::OpMulHi: begin
				mul_a = sd_pkg::MagW'(n_q);
				mul_b = sd_pkg::MagW'(s2_q[sd_pkg::SqSumW-1:sd_pkg::MagW]);
			end
			sd_pkg::OpMacLo: begin
				mul_a = sd_pkg::MagW'(n_q);
				mul_b = s2_q[sd_pkg::MagW-1:0];
			end
			sd_pkg::OpSubSq: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			sd_pkg::OpDen: begin
				mul_a = sd_pkg::MagW'(n_q);
				mul_b = sd_pkg::MagW'(n_q - 1'b1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign div_cat  = {rem_q[sd_pkg::DenW-1:0], num_q[sd_pkg::NumW-1]};
	assign div_diff = {1'b0, div_cat} - {2'b00, den_q};
	assign div_ok   = !div_diff[sd_pkg::DenW+1];

	assign sq_cat  = {rem_q, num_q[2*sd_pkg::DevW-1 -: 2]};
	assign sq_diff = {1'b0, sq_cat} - {3'b000, root_q, 2'b01};
	assign sq_ok   = !sq_diff[sd_pkg::RemW+2];

	always_ff @(posedge clk) begin
		if (load) begin
			n_q   <= n;
			mag_q <= mag;
			s2_q  <= s2;
		end else if (en) begin
			case (op)
				sd_pkg::OpMulHi: acc_q <= {prod[sd_pkg::AccW-sd_pkg::MagW-1:0],
						{sd_pkg::MagW{1'b0}}};
				sd_pkg::OpMacLo: acc_q <= acc_q + prod;
				sd_pkg::OpSubSq: acc_q <= acc_q - prod;
				sd_pkg::OpDen: begin
					den_q <= prod[sd_pkg::DenW-1:0];
					num_q <= {acc_q[sd_pkg::NumW-17:0], 16'h0000};
					rem_q <= '0;
				end
				sd_pkg::OpDivStep: begin
					rem_q <= div_ok ? sd_pkg::RemW'(div_diff[sd_pkg::DenW:0])
					                : sd_pkg::RemW'(div_cat);
					num_q <= {num_q[sd_pkg::NumW-2:0], div_ok};
				end
				sd_pkg::OpSqrtInit: begin
					rem_q  <= '0;
					root_q <= '0;
				end
				sd_pkg::OpSqrtStep: begin
					rem_q  <= sq_ok ? sq_diff[sd_pkg::RemW-1:0] : sq_cat[sd_pkg::RemW-1:0];
					root_q <= {root_q[sd_pkg::DevW-2:0], sq_ok};
					num_q  <= {num_q[sd_pkg::NumW-3:0], 2'b00};
				end
				default: begin
				end
			endcase
		end
	end

	assign deviation = root_q;

endmodule

// ----- hdl/sample_standard_deviation_core.sv -----
// Sample standard deviation core: stream accumulators, output register and
// glue around the microcoded sequencer. Depends on sd_pkg, sd_seq, sd_datapath.
//
// Usage:
//   Input channel (item_valid / item_stall / item) takes one signed 16-bit
//   sample per word; item.last marks the final sample of a vector. Samples
//   are accumulated at one word per cycle (count, sum, sum of squares in
//   combinational adders behind a 16x16 multiplier).
//   Output channel (result_valid / result_stall / result) gives one word per
//   vector: deviation (unsigned, 8 fraction bits) and status (0 ok, 1 fewer
//   than two samples, 2 more than 4096 samples). Samples past 4096 are dropped.
//   Timing: a vector with status 1 or 2 shows its result the cycle after the
//   last sample. Otherwise the sequencer runs its program (4 multiply steps,
//   71 divide steps, 1 setup step, 24 square-root steps, 1 write-back) and
//   the input stalls meanwhile. A last sample is stalled while the output
//   register holds an untaken word. When the receiver stalls, the result
//   holds in the output register and the sequencer waits on its final step.
//   Reset (arst_n low) clears the accumulators, sequencer and output valid.
module sample_standard_deviation_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sd_pkg::item_t    item,
	output logic             result_valid,
	input  logic             result_stall,
	output sd_pkg::result_t  result
);

	logic [sd_pkg::CountW-1:0]        count_q;
	logic signed [sd_pkg::SumW-1:0]   sum_q;
	logic [sd_pkg::SqSumW-1:0]        sqsum_q;
	logic                             ovf_q;

	logic [sd_pkg::CountW-1:0]        nxt_count;
	logic signed [sd_pkg::SumW-1:0]   nxt_sum;
	logic [sd_pkg::SqSumW-1:0]        nxt_sqsum;
	logic                             nxt_ovf;
	logic                             full;
	logic signed [31:0]               square;
	logic [sd_pkg::SumW-1:0]          abs_sum;

	logic                             accept_in;
	logic                             out_free;
	logic                             start;
	logic                             quick_done;
	logic                             seq_done;
	logic [1:0]                       quick_status;

	sd_pkg::uword_t                   uw;
	logic                             running;
	logic [sd_pkg::DevW-1:0]          deviation;

	sd_pkg::result_t                  result_q;
	logic                             result_valid_q;

	// Output register frees up when empty or being taken this cycle.
	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = running || (item.last && !out_free);
	assign accept_in  = item_valid && !item_stall;

	// Drop samples once the vector is full and remember it.
	assign full      = (count_q >= sd_pkg::CountW'(sd_pkg::MaxSamples));
	assign square    = $signed(item.sample) * $signed(item.sample);
	assign nxt_count = full ? count_q : count_q + 1'b1;
	assign nxt_sum   = full ? sum_q : sum_q + sd_pkg::SumW'($signed(item.sample));
	assign nxt_sqsum = full ? sqsum_q : sqsum_q + sd_pkg::SqSumW'($unsigned(square));
	assign nxt_ovf   = ovf_q || full;

	assign abs_sum = nxt_sum[sd_pkg::SumW-1] ? sd_pkg::SumW'(-nxt_sum)
	                                         : sd_pkg::SumW'(nxt_sum);

	assign start      = accept_in && item.last && !nxt_ovf
	                    && (nxt_count >= sd_pkg::CountW'(2));
	assign quick_done = accept_in && item.last && !start;
	assign quick_status = nxt_ovf ? sd_pkg::StatusOverflow : sd_pkg::StatusShort;
	assign seq_done   = running && (uw.op == sd_pkg::OpFinish) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept_in) begin
			if (item.last) begin
				// clear for the next vector
				count_q <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= nxt_count;
				sum_q   <= nxt_sum;
				sqsum_q <= nxt_sqsum;
				ovf_q   <= nxt_ovf;
			end
		end
	end

	sd_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.drain   (out_free),
		.uw      (uw),
		.running (running)
	);

	sd_datapath u_dp (
		.clk       (clk),
		.load      (start),
		.n         (nxt_count),
		.mag       (abs_sum[sd_pkg::MagW-1:0]),
		.s2        (nxt_sqsum),
		.en        (running),
		.op        (uw.op),
		.deviation (deviation)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (quick_done || seq_done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (quick_done) begin
			result_q.deviation <= '0;
			result_q.status    <= quick_status;
		end else if (seq_done) begin
			result_q.deviation <= deviation;
			result_q.status    <= sd_pkg::StatusOk;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
